[hw/rtl/noise_gate_and_compressor_defines.svh]
// ---------------------------------------------------------------------------
// noise gate and compressor assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef NOISE_GATE_AND_COMPRESSOR_DEFINES_SVH
`define NOISE_GATE_AND_COMPRESSOR_DEFINES_SVH

// condition holds at every edge
`define NGC_ASSERT_NOW(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// condition in one cycle implies another in the next
`define NGC_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/ngc_pkg.sv]
// ---------------------------------------------------------------------------
// ngc_pkg
// types, constants and lookup tables of the noise gate and compressor
// ---------------------------------------------------------------------------
package ngc_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int TAB_LEN        = 1 << LOG_TABLE_BITS;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 23;

    localparam logic [16:0] UNITY       = 17'd32768;
    localparam logic [31:0] ENV_FLOOR   = 32'd2147;
    localparam logic [18:0] DB_PER_OCT  = 19'd394566;
    localparam logic [13:0] OCT_PER_DB  = 14'd10885;
    localparam logic [9:0]  GATE_GLIDE  = 10'd131;
    localparam logic [9:0]  COMP_GLIDE  = 10'd655;

    localparam logic [22:0]        RST_GATE_THR  = 23'd83886;
    localparam logic [15:0]        RST_GATE_ATT  = 16'd3277;
    localparam logic [15:0]        RST_GATE_COEF = 16'd65263;
    localparam logic signed [14:0] RST_COMP_THR  = -15'sd5120;
    localparam logic [16:0]        RST_COMP_INV  = 17'd16384;
    localparam logic [15:0]        RST_ATTACK    = 16'd65400;
    localparam logic [15:0]        RST_RELEASE   = 16'd65527;

    typedef enum logic [CFG_AW-1:0] {
        CFG_GATE_THRESHOLD = 3'd0,
        CFG_GATE_ATTEN     = 3'd1,
        CFG_GATE_COEFF     = 3'd2,
        CFG_COMP_THRESHOLD = 3'd3,
        CFG_COMP_INV_RATIO = 3'd4,
        CFG_ATTACK_COEFF   = 3'd5,
        CFG_RELEASE_COEFF  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] gate_level;
        logic [16:0] gate_gain;
        logic [31:0] comp_level;
        logic [16:0] comp_gain;
    } chan_state_t;

    localparam chan_state_t STATE_RESET = '{
        gate_level: 32'd0,
        gate_gain:  UNITY,
        comp_level: 32'd0,
        comp_gain:  UNITY
    };

    typedef logic [16:0] tab_t [TAB_LEN];

    function automatic logic [63:0] isqrt(logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] b;
        a = a_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > a) b = b >> 2;
        while (b != 64'd0) begin
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic tab_t build_log2_tab();
        tab_t        t;
        logic [63:0] m;
        logic [16:0] res;
        for (int i = 0; i < TAB_LEN; i++) begin
            m   = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
            res = 17'd0;
            for (int k = 0; k < 16; k++) begin
                m   = (m * m) >> 30;
                res = res << 1;
                if (m >= (64'd1 << 31)) begin
                    m   = m >> 1;
                    res = res | 17'd1;
                end
            end
            t[i] = res;
        end
        return t;
    endfunction

    function automatic tab_t build_exp2_tab();
        tab_t        t;
        logic [63:0] v;
        logic [63:0] e;
        v = 64'd1 << 29;
        e = 64'd1 << 30;
        for (int i = 0; i < LOG_TABLE_BITS; i++) v = isqrt(v << 30);
        for (int i = 0; i < TAB_LEN; i++) begin
            t[i] = 17'((e + 64'd8192) >> 14);
            e    = (e * v + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction

    localparam tab_t LOG2_TAB = build_log2_tab();
    localparam tab_t EXP2_TAB = build_exp2_tab();

    function automatic logic [23:0] abs24(logic [23:0] v);
        return v[23] ? (~v + 24'd1) : v;
    endfunction

endpackage

[hw/rtl/noise_gate_and_compressor.sv]
// ---------------------------------------------------------------------------
// noise_gate_and_compressor
// per-channel noise gate followed by a peak compressor on Q1.23 samples
// ---------------------------------------------------------------------------
//  channel   direction  ports                                   beat
//  s_        in         s_channel, s_sample_in                  one sample
//  m_        out        m_channel_out, m_sample_out, m_gate_open one result
//  cfg_      in         cfg_addr, cfg_wdata                     one register
//
//  one sample at a time; the time from accept to result grows with each
//  normalizer shift (0 to 20) and when the compressor reduces gain
//  state per channel lives in one memory read at accept, written at the end
//  a finished result waits in the output register while the next sample runs
//  synchronous active-low reset, no clearing pass
// ---------------------------------------------------------------------------
module noise_gate_and_compressor import ngc_pkg::*; #(
    parameter int CHANNELS = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_channel,
    input  logic signed [23:0] s_sample_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_channel_out,
    output logic signed [23:0] m_sample_out,
    output logic               m_gate_open,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_LOAD  = 21'h000002,
        S_GF1   = 21'h000004,
        S_GF2   = 21'h000008,
        S_GAIM  = 21'h000010,
        S_GMAG  = 21'h000020,
        S_GSTEP = 21'h000040,
        S_GMUL  = 21'h000080,
        S_GSAT  = 21'h000100,
        S_CF1   = 21'h000200,
        S_CF2   = 21'h000400,
        S_LDB   = 21'h000800,
        S_LWAIT = 21'h001000,
        S_THR   = 21'h002000,
        S_RED   = 21'h004000,
        S_TGT   = 21'h008000,
        S_CMAG  = 21'h010000,
        S_CSTEP = 21'h020000,
        S_CMUL  = 21'h040000,
        S_CSAT  = 21'h080000,
        S_DONE  = 21'h100000
    } state_t;

    // configuration
    logic [22:0]        gate_thr_reg;
    logic [15:0]        gate_att_reg;
    logic [15:0]        gate_coef_reg;
    logic signed [14:0] comp_thr_reg;
    logic [16:0]        comp_inv_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_thr_reg  <= RST_GATE_THR;
            gate_att_reg  <= RST_GATE_ATT;
            gate_coef_reg <= RST_GATE_COEF;
            comp_thr_reg  <= RST_COMP_THR;
            comp_inv_reg  <= RST_COMP_INV;
            attack_reg    <= RST_ATTACK;
            release_reg   <= RST_RELEASE;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_GATE_THRESHOLD: gate_thr_reg  <= cfg_wdata[22:0];
                CFG_GATE_ATTEN:     gate_att_reg  <= cfg_wdata[15:0];
                CFG_GATE_COEFF:     gate_coef_reg <= cfg_wdata[15:0];
                CFG_COMP_THRESHOLD: comp_thr_reg  <= $signed(cfg_wdata[14:0]);
                CFG_COMP_INV_RATIO: comp_inv_reg  <= cfg_wdata[16:0];
                CFG_ATTACK_COEFF:   attack_reg    <= cfg_wdata[15:0];
                CFG_RELEASE_COEFF:  release_reg   <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // working registers
    state_t             state_reg, state_next;
    logic               chan_reg;
    logic [AW-1:0]      addr_reg;
    logic signed [23:0] smp_reg;
    logic [23:0]        lvl_reg;
    logic [31:0]        gl_reg;
    logic [16:0]        gg_reg;
    logic [31:0]        cl_reg;
    logic [16:0]        cg_reg;
    logic [15:0]        coef_reg;
    logic [48:0]        prod_reg;
    logic               open_reg;
    logic [16:0]        aim_reg;
    logic [16:0]        mag_reg;
    logic               down_reg;
    logic               neg_reg;

    logic               m_valid_reg;
    logic               m_chan_reg;
    logic signed [23:0] m_smp_reg;
    logic               m_open_reg;

    logic               accept;
    logic               out_free;
    logic [AW-1:0]      chan_idx;
    chan_state_t        rd_data;
    chan_state_t        wr_data;
    logic               ldb_done;
    logic signed [16:0] ldb_db;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign chan_idx = (32'(s_channel) >= CHANNELS) ? AW'(CHANNELS - 1) : AW'(s_channel);
    assign wr_data  = '{gate_level: gl_reg, gate_gain: gg_reg,
                        comp_level: cl_reg, comp_gain: cg_reg};

    ngc_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (chan_idx),
        .rd_data (rd_data),
        .wr_en   ((state_reg == S_DONE) && out_free),
        .wr_addr (addr_reg),
        .wr_data (wr_data)
    );

    ngc_level_db u_ldb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_LDB),
        .env     (cl_reg),
        .done    (ldb_done),
        .db      (ldb_db)
    );

    // shared datapath pieces
    logic               comp_phase;
    logic [16:0]        gain_cur;
    logic [9:0]         glide_k;
    logic [16:0]        coef_inv;
    logic [48:0]        follow_sum;
    logic [25:0]        step_sum;
    logic [16:0]        step;
    logic [16:0]        gain_new;
    logic [33:0]        gm_r;
    logic signed [23:0] gm_sat;
    logic [23:0]        det;
    logic [15:0]        env_coef;
    logic signed [16:0] thr17;
    logic signed [16:0] over;
    logic [16:0]        inv_lim;
    logic [48:0]        red_sum;
    logic [48:0]        l_sum;
    logic [6:0]         l_int;
    logic [21:0]        tgt_sum;
    logic [21:0]        tgt_shift;

    always_comb begin
        comp_phase = state_reg inside {S_CMAG, S_CSTEP, S_CMUL, S_CSAT};
        gain_cur   = comp_phase ? cg_reg : gg_reg;
        glide_k    = comp_phase ? COMP_GLIDE : GATE_GLIDE;

        coef_inv   = 17'd65536 - {1'b0, coef_reg};
        follow_sum = prod_reg + ({32'd0, coef_inv} * {17'd0, lvl_reg, 8'd0});

        step_sum   = {1'b0, prod_reg[24:0]} + 26'd32768;
        step       = {7'd0, step_sum[25:16]};
        if (step == 17'd0 && mag_reg != 17'd0) begin
            step = 17'd1;
        end
        gain_new   = down_reg ? (gain_cur - step) : (gain_cur + step);

        gm_r = 34'((prod_reg + 49'd16384) >> 15);
        if (!neg_reg) begin
            gm_sat = (gm_r > 34'd8388607) ? 24'sh7FFFFF : $signed(gm_r[23:0]);
        end else begin
            gm_sat = (gm_r > 34'd8388608) ? 24'sh800000 : $signed(~gm_r[23:0] + 24'd1);
        end

        det      = abs24(smp_reg);
        env_coef = ({det, 8'd0} > cl_reg) ? attack_reg : release_reg;

        thr17    = {{2{comp_thr_reg[14]}}, comp_thr_reg};
        over     = ldb_db - thr17;
        inv_lim  = (comp_inv_reg > 17'd65536) ? 17'd65536 : comp_inv_reg;
        red_sum  = prod_reg + 49'd32768;
        l_sum    = prod_reg + 49'd128;
        l_int    = l_sum[30:24];
        tgt_sum  = {5'd0, EXP2_TAB[l_sum[23 -: LOG_TABLE_BITS]]} + (22'd1 << l_int);
        tgt_shift = tgt_sum >> (l_int + 7'd1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_LOAD;
            S_LOAD:  state_next = S_GF1;
            S_GF1:   state_next = S_GF2;
            S_GF2:   state_next = S_GAIM;
            S_GAIM:  state_next = S_GMAG;
            S_GMAG:  state_next = S_GSTEP;
            S_GSTEP: state_next = S_GMUL;
            S_GMUL:  state_next = S_GSAT;
            S_GSAT:  state_next = S_CF1;
            S_CF1:   state_next = S_CF2;
            S_CF2:   state_next = S_LDB;
            S_LDB:   state_next = S_LWAIT;
            S_LWAIT: if (ldb_done) state_next = S_THR;
            S_THR:   state_next = (ldb_db <= thr17) ? S_CMAG : S_RED;
            S_RED:   state_next = S_TGT;
            S_TGT:   state_next = S_CMAG;
            S_CMAG:  state_next = S_CSTEP;
            S_CSTEP: state_next = S_CMUL;
            S_CMUL:  state_next = S_CSAT;
            S_CSAT:  state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    chan_reg <= s_channel;
                    addr_reg <= chan_idx;
                    smp_reg  <= s_sample_in;
                end
            end
            S_LOAD: begin
                gl_reg  <= rd_data.gate_level;
                gg_reg  <= rd_data.gate_gain;
                cl_reg  <= rd_data.comp_level;
                cg_reg  <= rd_data.comp_gain;
                lvl_reg <= det;
            end
            S_GF1: begin
                coef_reg <= gate_coef_reg;
                prod_reg <= {33'd0, gate_coef_reg} * {17'd0, gl_reg};
            end
            S_GF2: begin
                gl_reg <= follow_sum[47:16];
            end
            S_GAIM: begin
                open_reg <= (gl_reg >= {1'b0, gate_thr_reg, 8'd0});
                if (gl_reg >= {1'b0, gate_thr_reg, 8'd0}) begin
                    aim_reg <= UNITY;
                end else begin
                    aim_reg <= ({1'b0, gate_att_reg} > UNITY) ? UNITY : {1'b0, gate_att_reg};
                end
            end
            S_GMAG, S_CMAG: begin
                down_reg <= gain_cur > aim_reg;
                mag_reg  <= (gain_cur > aim_reg) ? (gain_cur - aim_reg) : (aim_reg - gain_cur);
                prod_reg <= {39'd0, glide_k} *
                            {32'd0, (gain_cur > aim_reg) ? (gain_cur - aim_reg)
                                                         : (aim_reg - gain_cur)};
            end
            S_GSTEP: begin
                gg_reg <= gain_new;
            end
            S_CSTEP: begin
                cg_reg <= gain_new;
            end
            S_GMUL, S_CMUL: begin
                neg_reg  <= smp_reg[23];
                prod_reg <= {25'd0, det} * {32'd0, gain_cur};
            end
            S_GSAT, S_CSAT: begin
                smp_reg <= gm_sat;
            end
            S_CF1: begin
                lvl_reg  <= det;
                coef_reg <= env_coef;
                prod_reg <= {33'd0, env_coef} * {17'd0, cl_reg};
            end
            S_CF2: begin
                cl_reg <= follow_sum[47:16];
            end
            S_THR: begin
                if (ldb_db <= thr17) begin
                    aim_reg <= UNITY;
                end else begin
                    prod_reg <= {32'd0, over[16:0]} * {32'd0, 17'(17'd65536 - inv_lim)};
                end
            end
            S_RED: begin
                prod_reg <= {32'd0, red_sum[32:16]} * {35'd0, OCT_PER_DB};
            end
            S_TGT: begin
                aim_reg <= (l_int > 7'd20) ? 17'd0 : tgt_shift[16:0];
            end
            S_DONE: begin
                if (out_free) begin
                    m_chan_reg <= chan_reg;
                    m_smp_reg  <= smp_reg;
                    m_open_reg <= open_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_chan_reg;
    assign m_sample_out  = m_smp_reg;
    assign m_gate_open   = m_open_reg;

endmodule

[hw/rtl/ngc_state_mem.sv]
// ---------------------------------------------------------------------------
// ngc_state_mem
// per-channel state memory, registered read, entries read as reset until written
// ---------------------------------------------------------------------------
module ngc_state_mem import ngc_pkg::*; #(
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output chan_state_t       rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  chan_state_t       wr_data
);

    chan_state_t            mem [DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    chan_state_t            rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : STATE_RESET;

endmodule

[hw/rtl/ngc_level_db.sv]
// ---------------------------------------------------------------------------
// ngc_level_db
// envelope to dB Q8.8, bit-serial normalize then log2 table and scale
// ---------------------------------------------------------------------------
module ngc_level_db import ngc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        env,
    output logic               done,
    output logic signed [16:0] db
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_MUL  = 4'b0100,
        L_RND  = 4'b1000
    } lstate_t;

    lstate_t            lst_reg, lst_next;
    logic [31:0]        m_reg;
    logic [4:0]         p_reg;
    logic [39:0]        prod_reg;
    logic signed [16:0] db_reg;
    logic               done_reg;

    logic [LOG_TABLE_BITS-1:0] idx;
    logic [16:0]               frac;
    logic [20:0]               mag;
    logic [39:0]               rnd;

    always_comb begin
        idx  = m_reg[30 -: LOG_TABLE_BITS];
        frac = LOG2_TAB[idx];
        if (p_reg == 5'd31) begin
            mag = {4'd0, frac};
        end else begin
            mag = {5'(5'd31 - p_reg), 16'd0} - {4'd0, frac};
        end
        rnd = prod_reg + 40'h80_0000;
    end

    always_comb begin
        lst_next = lst_reg;
        case (lst_reg)
            L_IDLE:  if (start) lst_next = L_NORM;
            L_NORM:  if (m_reg[31]) lst_next = L_MUL;
            L_MUL:   lst_next = L_RND;
            L_RND:   lst_next = L_IDLE;
            default: lst_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lst_reg  <= L_IDLE;
            done_reg <= 1'b0;
        end else begin
            lst_reg  <= lst_next;
            done_reg <= (lst_reg == L_RND);
        end
    end

    always_ff @(posedge aclk) begin
        case (lst_reg)
            L_IDLE: begin
                if (start) begin
                    m_reg <= (env < ENV_FLOOR) ? ENV_FLOOR : env;
                    p_reg <= 5'd31;
                end
            end
            L_NORM: begin
                if (!m_reg[31]) begin
                    m_reg <= {m_reg[30:0], 1'b0};
                    p_reg <= p_reg - 5'd1;
                end
            end
            L_MUL: begin
                prod_reg <= {19'd0, mag} * {21'd0, DB_PER_OCT};
            end
            L_RND: begin
                db_reg <= -$signed({1'b0, rnd[39:24]});
            end
            default: begin
            end
        endcase
    end

    assign done = done_reg;
    assign db   = db_reg;

endmodule

[hw/rtl/ngc_checker.sv]
// ---------------------------------------------------------------------------
// ngc_checker
// port-level checks of the noise gate and compressor, bound to the top level
// ---------------------------------------------------------------------------
`include "noise_gate_and_compressor_defines.svh"

module ngc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_channel_out,
    input logic signed [23:0] m_sample_out,
    input logic               m_gate_open
);

    logic [7:0] in_cnt_reg;
    logic [7:0] out_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_cnt_reg  <= 8'd0;
            out_cnt_reg <= 8'd0;
        end else begin
            in_cnt_reg  <= in_cnt_reg + 8'(s_valid && s_ready);
            out_cnt_reg <= out_cnt_reg + 8'(m_valid && m_ready);
        end
    end

    // one sample in work at a time
    `NGC_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second beat taken during work")

    // a result needs a sample behind it
    `NGC_ASSERT_NOW(a_no_invented, aclk, aresetn, !m_valid || (in_cnt_reg != out_cnt_reg), "result without input")

    // busy only with a sample pending
    `NGC_ASSERT_NOW(a_busy_pending, aclk, aresetn, s_ready || (in_cnt_reg != out_cnt_reg), "busy with nothing pending")

    `NGC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_out) && $stable(m_channel_out) && $stable(m_gate_open), "stalled result changed")

endmodule

bind noise_gate_and_compressor ngc_checker u_ngc_checker (.*);
